/* rtl/lmfrs_pkg.sv */
// shared constants, types and command/status structs of the led matrix row scanner
// no dependencies; used by every module of the block by scoped names
package lmfrs_pkg;

	localparam int ROWS     = 6;
	localparam int COLS     = 12;
	localparam int PAD_BITS = 2;

	localparam int KIND_W    = 2;
	localparam int ROW_IN_W  = 3;
	localparam int PAT_W     = 12;
	localparam int XPOS_W    = 4;
	localparam int WIDTH_W   = 4;
	localparam int S_DATA_W  = 24;
	localparam int M_DATA_W  = 8;

	localparam int STREAM_BITS = COLS + PAD_BITS + ROWS;
	localparam int ROW_IDX_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CNT_W       = $clog2(STREAM_BITS + 1);
	localparam int PLACE_W     = PAT_W + COLS;
	localparam int SH_W        = 7;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_SCAN   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_SHIFT = 1'b1
	} state_t;

	typedef struct packed {
		logic clear;
		logic insert;
		logic load;
		logic shift;
	} cmd_t;

	typedef struct packed {
		logic last;
	} status_t;

endpackage

/* rtl/lmfrs_ctrl.sv */
// controller state machine of the led matrix row scanner
// decodes the word kind and sequences the serial stream; uses lmfrs_pkg
module lmfrs_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [lmfrs_pkg::KIND_W-1:0] in_kind,
	output logic                      in_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	input  lmfrs_pkg::status_t        status,
	output lmfrs_pkg::cmd_t           cmd
);

	lmfrs_pkg::state_t state_q;
	lmfrs_pkg::state_t state_next;
	lmfrs_pkg::kind_t  kind;

	assign kind = lmfrs_pkg::kind_t'(in_kind);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmfrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			lmfrs_pkg::ST_IDLE: begin
				if (in_valid && kind == lmfrs_pkg::KIND_SCAN) begin
					state_next = lmfrs_pkg::ST_SHIFT;
				end
			end
			lmfrs_pkg::ST_SHIFT: begin
				if (out_ready && status.last) begin
					state_next = lmfrs_pkg::ST_IDLE;
				end
			end
			default: state_next = lmfrs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		cmd        = '0;
		unique case (state_q)
			lmfrs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (kind)
						lmfrs_pkg::KIND_CLEAR:  cmd.clear  = 1'b1;
						lmfrs_pkg::KIND_INSERT: cmd.insert = 1'b1;
						lmfrs_pkg::KIND_SCAN:   cmd.load   = 1'b1;
						default: ;
					endcase
				end
			end
			lmfrs_pkg::ST_SHIFT: begin
				out_valid = 1'b1;
				cmd.shift = out_ready;
			end
			default: ;
		endcase
	end

endmodule

/* rtl/lmfrs_dp.sv */
// datapath of the led matrix row scanner: frame store, insert placement,
// row pointer and serial shift register; uses lmfrs_pkg
module lmfrs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lmfrs_pkg::cmd_t               cmd,
	output lmfrs_pkg::status_t            status,
	input  logic [lmfrs_pkg::ROW_IN_W-1:0] row,
	input  logic [lmfrs_pkg::PAT_W-1:0]   pattern,
	input  logic [lmfrs_pkg::XPOS_W-1:0]  x_pos,
	input  logic [lmfrs_pkg::WIDTH_W-1:0] width,
	output logic                          serial_data,
	output logic                          latch
);

	logic [lmfrs_pkg::COLS-1:0]        frame_q [lmfrs_pkg::ROWS];
	logic [lmfrs_pkg::ROW_IDX_W-1:0]   scan_row_q;
	logic [lmfrs_pkg::STREAM_BITS-1:0] sr_q;
	logic [lmfrs_pkg::CNT_W-1:0]       cnt_q;

	logic [lmfrs_pkg::WIDTH_W-1:0]     w_eff;
	logic [lmfrs_pkg::PAT_W:0]         mask_ext;
	logic [lmfrs_pkg::PLACE_W-1:0]     bits_ext;
	logic [lmfrs_pkg::PLACE_W-1:0]     placed;
	logic [lmfrs_pkg::SH_W-1:0]        sh;
	logic [lmfrs_pkg::SH_W-1:0]        sh_neg;
	logic                              row_ok;
	logic [lmfrs_pkg::COLS-1:0]        line;
	logic [lmfrs_pkg::ROWS-1:0]        sel;
	logic [lmfrs_pkg::STREAM_BITS-1:0] stream;

	// insert placement
	always_comb begin
		w_eff    = (width > lmfrs_pkg::WIDTH_W'(lmfrs_pkg::PAT_W))
			? lmfrs_pkg::WIDTH_W'(lmfrs_pkg::PAT_W) : width;
		mask_ext = ((lmfrs_pkg::PAT_W+1)'(1) << w_eff) - (lmfrs_pkg::PAT_W+1)'(1);
		bits_ext = lmfrs_pkg::PLACE_W'(pattern & mask_ext[lmfrs_pkg::PAT_W-1:0]);
		sh       = lmfrs_pkg::SH_W'(lmfrs_pkg::COLS)
			- lmfrs_pkg::SH_W'(x_pos) - lmfrs_pkg::SH_W'(w_eff);
		sh_neg   = lmfrs_pkg::SH_W'(0) - sh;
		if (sh[lmfrs_pkg::SH_W-1]) begin
			placed = bits_ext >> sh_neg[lmfrs_pkg::SH_W-2:0];
		end else begin
			placed = bits_ext << sh[lmfrs_pkg::SH_W-2:0];
		end
		row_ok = (row < lmfrs_pkg::ROW_IN_W'(lmfrs_pkg::ROWS)) && (w_eff != '0);
	end

	// stream of the current row
	always_comb begin
		line   = frame_q[scan_row_q];
		sel    = ~((line != '0) ? (lmfrs_pkg::ROWS'(1) << scan_row_q) : '0);
		stream = {sel, {lmfrs_pkg::PAD_BITS{1'b1}}, line};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < lmfrs_pkg::ROWS; r++) begin
				frame_q[r] <= '0;
			end
		end else if (cmd.clear) begin
			for (int r = 0; r < lmfrs_pkg::ROWS; r++) begin
				frame_q[r] <= '0;
			end
		end else if (cmd.insert && row_ok) begin
			frame_q[row[lmfrs_pkg::ROW_IDX_W-1:0]] <=
				frame_q[row[lmfrs_pkg::ROW_IDX_W-1:0]] | placed[lmfrs_pkg::COLS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q <= '0;
			cnt_q      <= '0;
		end else if (cmd.load) begin
			scan_row_q <= (scan_row_q == lmfrs_pkg::ROW_IDX_W'(lmfrs_pkg::ROWS - 1))
				? '0 : scan_row_q + lmfrs_pkg::ROW_IDX_W'(1);
			cnt_q      <= '0;
		end else if (cmd.shift) begin
			cnt_q <= cnt_q + lmfrs_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sr_q <= stream;
		end else if (cmd.shift) begin
			sr_q <= sr_q >> 1;
		end
	end

	assign status.last = (cnt_q == lmfrs_pkg::CNT_W'(lmfrs_pkg::STREAM_BITS - 1));
	assign serial_data = sr_q[0];
	assign latch       = status.last;

endmodule

/* rtl/led_matrix_frame_and_row_scanner_unit.sv */
// top level of the led matrix frame store and row scanner
// instantiates lmfrs_ctrl and lmfrs_dp; uses lmfrs_pkg
//
// The block holds a 6 by 12 monochrome frame, zero after reset. Each input word
// carries a kind in s_axis_tuser: clear zeroes the frame, insert ORs the low width
// bits of pattern into one row with its top bit at column 11 - x_pos, and scan
// sends the next row out as 20 output words, one serial bit each: 12 column bits
// from column 0, two padding ones, then six row selects, low for the scanned row
// only when it is lit; tlast marks the latch bit. Clear and insert act on the word
// as it is taken; a scan loads the shift register, then shifts it out one bit per
// output word, holding while m_axis_tready is low. No input is taken while a scan
// is being shifted out.
module led_matrix_frame_and_row_scanner_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// row[2:0], pattern[14:3], x_pos[18:15], width[22:19], zero fill
	input  logic [lmfrs_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// kind[1:0]
	input  logic [lmfrs_pkg::KIND_W-1:0]    s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// serial_data[0], zero fill
	output logic [lmfrs_pkg::M_DATA_W-1:0]  m_axis_tdata,
	// latch
	output logic                            m_axis_tlast
);

	lmfrs_pkg::cmd_t    cmd;
	lmfrs_pkg::status_t status;
	logic               serial_data;

	lmfrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_kind   (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	lmfrs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.row         (s_axis_tdata[2:0]),
		.pattern     (s_axis_tdata[14:3]),
		.x_pos       (s_axis_tdata[18:15]),
		.width       (s_axis_tdata[22:19]),
		.serial_data (serial_data),
		.latch       (m_axis_tlast)
	);

	assign m_axis_tdata = {(lmfrs_pkg::M_DATA_W-1)'(0), serial_data};

endmodule

/* rtl/lmfrs_chk.sv */
// port-level checker for the led matrix row scanner, bound to the top level
// depends on lmfrs_pkg and led_matrix_frame_and_row_scanner_unit
module lmfrs_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [lmfrs_pkg::KIND_W-1:0]   s_axis_tuser,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [lmfrs_pkg::M_DATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input taken while a row is shifting out");

	a_scan_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=>
			m_axis_tvalid == ($past(s_axis_tuser) == lmfrs_pkg::KIND_SCAN))
		else $error("scan word did not start a stream, or another kind did");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
		else $error("stream continued past latch bit");

	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[lmfrs_pkg::M_DATA_W-1:1] == '0)
		else $error("output fill bits not zero");

endmodule

bind led_matrix_frame_and_row_scanner_unit lmfrs_chk u_lmfrs_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
